// ===== hdl/vxf_pkg.sv =====
// ----------------------------------------------------------------------------
// vxf_pkg: shared types and constants of the vertex transform block
// Widths of the datapath, request codes, sequencer states and the reset
// contents of the matrix store.
// ----------------------------------------------------------------------------
package vxf_pkg;

  // Field and datapath widths
  localparam int DATA_W    = 32;            // Q16.16 word
  localparam int FRAC_W    = 16;            // fraction bits of Q16.16
  localparam int PROD_W    = 2 * DATA_W;    // exact Q32.32 product
  localparam int MAC_W     = PROD_W + 2;    // sum of four products plus rounding
  localparam int COL_W     = MAC_W - FRAC_W; // column result in Q34.16
  localparam int MAG_W     = COL_W;         // divider operand magnitude
  localparam int QUO_W     = 34;            // quotient bits kept by the divider
  localparam int QR_W      = QUO_W + 1;     // quotient after rounding
  localparam int INIT_SH   = QUO_W - FRAC_W; // low numerator bits shifted in by the divider
  localparam int OVF_SH    = QUO_W - 1 - FRAC_W; // quotient too large to keep
  localparam int LANES     = 3;             // x, y and reciprocal lanes
  localparam int ENTRIES   = 16;
  localparam int IDX_W     = 4;

  // Request codes
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_XFORM   = 2'd1;
  localparam logic [1:0] REQ_PROJECT = 2'd2;

  // Sequencer counts
  localparam logic [3:0] MAC_STEPS = 4'd12;  // three columns of four rows
  localparam logic [5:0] DIV_LAST  = 6'd33;  // QUO_W steps, counted from zero

  localparam logic [DATA_W-1:0] ONE_Q16    = 32'h0001_0000;
  localparam logic [MAC_W-1:0]  ROUND_HALF = MAC_W'(32768);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SETUP,
    ST_DIV,
    ST_ROUND,
    ST_DONE
  } vxf_state_t;

  // Matrix store contents after reset: identity in Q16.16
  function automatic logic [DATA_W-1:0] entry_reset(input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] val;
    case (idx)
      4'd0, 4'd5, 4'd10, 4'd15: val = ONE_Q16;
      default:                  val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/vertex_transform_project.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_project: 4x4 homogeneous vertex transform with divide
// Holds a Q16.16 matrix in a small synchronous memory, forms column sums on
// one shared multiplier and runs the perspective divide on a serial divider.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in_      | in_valid / in_ready    | req_type, entry_index, entry_value,
//           |                        | point_x, point_y, point_z
//  out_     | out_valid / out_ready  | out_x, out_y, out_z, divide_fault,
//           |                        | saturated
//
//  A write request is taken without leaving idle. For a transform request,
//  twelve reads of the matrix memory, one per cycle,
//  feed the single 32x32 multiplier, plus pipeline drain and clamp.
//  A project request with nonzero w adds 34 steps of the bit-serial divider
//  (three lanes in step) and a rounding state.
//  Reset clears per-entry valid bits so the matrix reads as identity at once.
//  A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module vertex_transform_project #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [3:0]         in_entry_index,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_divide_fault,
  output logic               out_saturated
);

  // Clamp range: signed min(COORD_WIDTH, 32) bits
  localparam int OUT_BITS = (COORD_WIDTH > vxf_pkg::DATA_W) ? vxf_pkg::DATA_W : COORD_WIDTH;
  localparam longint SAT_HI_L  = (longint'(1) <<< (OUT_BITS - 1)) - longint'(1);
  localparam longint SAT_LO_L  = -SAT_HI_L - longint'(1);
  localparam longint SAT_MAG_L = SAT_HI_L + longint'(1);
  localparam logic signed [vxf_pkg::COL_W-1:0] COL_HI = SAT_HI_L[vxf_pkg::COL_W-1:0];
  localparam logic signed [vxf_pkg::COL_W-1:0] COL_LO = SAT_LO_L[vxf_pkg::COL_W-1:0];
  localparam logic [vxf_pkg::DATA_W-1:0] OUT_MAX = SAT_HI_L[vxf_pkg::DATA_W-1:0];
  localparam logic [vxf_pkg::DATA_W-1:0] OUT_MIN = SAT_LO_L[vxf_pkg::DATA_W-1:0];
  localparam logic [vxf_pkg::QR_W-1:0]   QLIM_POS = SAT_HI_L[vxf_pkg::QR_W-1:0];
  localparam logic [vxf_pkg::QR_W-1:0]   QLIM_NEG = SAT_MAG_L[vxf_pkg::QR_W-1:0];

  vxf_pkg::vxf_state_t state_r, state_nxt;

  logic in_fire;
  logic out_load;

  // Request registers
  logic                              proj_r;
  logic signed [vxf_pkg::DATA_W-1:0] pt_x_r, pt_y_r, pt_z_r;

  // Matrix memory and its valid bits
  logic [vxf_pkg::DATA_W-1:0]  mat_mem [vxf_pkg::ENTRIES];
  logic [vxf_pkg::ENTRIES-1:0] ent_vld_r;
  logic [vxf_pkg::IDX_W-1:0]   rd_addr;
  logic [vxf_pkg::IDX_W-1:0]   rd_idx_r;
  logic [vxf_pkg::DATA_W-1:0]  rd_data_r;
  logic                        rd_hit_r;

  // Multiply-accumulate pipeline
  logic [3:0]                        cnt_r;
  logic                              issue;
  logic [1:0]                        iss_col;
  logic                              s1_vld_r, s2_vld_r;
  logic [1:0]                        s1_row_r, s1_slot_r, s2_slot_r;
  logic signed [vxf_pkg::DATA_W-1:0] ent_val, op_val;
  logic signed [vxf_pkg::PROD_W-1:0] prod_nxt, prod_r;
  logic signed [vxf_pkg::MAC_W-1:0]  acc_r [vxf_pkg::LANES];
  logic signed [vxf_pkg::COL_W-1:0]  col_v [vxf_pkg::LANES];
  logic                              w_zero;

  // Divider lanes
  logic [5:0]                 step_r;
  logic [vxf_pkg::MAG_W-1:0]  den_r;
  logic [vxf_pkg::MAG_W-1:0]  num_mag_r [vxf_pkg::LANES];
  logic                       neg_r     [vxf_pkg::LANES];
  logic [vxf_pkg::MAG_W-1:0]  rem_r     [vxf_pkg::LANES];
  logic [vxf_pkg::QUO_W-1:0]  lo_r      [vxf_pkg::LANES];
  logic [vxf_pkg::QUO_W-1:0]  quo_r     [vxf_pkg::LANES];
  logic [vxf_pkg::MAG_W-1:0]  num_mag   [vxf_pkg::LANES];
  logic                       num_neg   [vxf_pkg::LANES];
  logic [vxf_pkg::MAG_W-1:0]  w_mag;
  logic [vxf_pkg::MAG_W:0]    trial     [vxf_pkg::LANES];
  logic [vxf_pkg::MAG_W:0]    diff      [vxf_pkg::LANES];
  logic                       trial_ge  [vxf_pkg::LANES];

  // Result staging and output registers
  logic                       res_load;
  logic [vxf_pkg::DATA_W-1:0] res_nxt [vxf_pkg::LANES];
  logic [vxf_pkg::DATA_W-1:0] res_r   [vxf_pkg::LANES];
  logic                       res_fault_nxt, res_sat_nxt;
  logic                       res_fault_r, res_sat_r;
  logic                       out_valid_r;
  logic [vxf_pkg::DATA_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                       out_fault_r, out_sat_r;

  assign in_fire = in_valid && in_ready;

  // Sequencer: next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      vxf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_req_type == vxf_pkg::REQ_XFORM ||
                         in_req_type == vxf_pkg::REQ_PROJECT)) begin
          state_nxt = vxf_pkg::ST_MAC;
        end
      end
      vxf_pkg::ST_MAC: begin
        if (cnt_r == vxf_pkg::MAC_STEPS && !s1_vld_r && !s2_vld_r) begin
          state_nxt = vxf_pkg::ST_SETUP;
        end
      end
      vxf_pkg::ST_SETUP: begin
        if (proj_r && !w_zero) begin
          state_nxt = vxf_pkg::ST_DIV;
        end else begin
          state_nxt = vxf_pkg::ST_DONE;
        end
      end
      vxf_pkg::ST_DIV: begin
        if (step_r == vxf_pkg::DIV_LAST) begin
          state_nxt = vxf_pkg::ST_ROUND;
        end
      end
      vxf_pkg::ST_ROUND: begin
        state_nxt = vxf_pkg::ST_DONE;
      end
      vxf_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = vxf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vxf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vxf_pkg::ST_IDLE;
      ent_vld_r   <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      if (in_fire && in_req_type == vxf_pkg::REQ_WRITE) begin
        ent_vld_r[in_entry_index] <= 1'b1;
      end
      if (in_fire) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 4'd1;
      end
      if (state_r == vxf_pkg::ST_DIV) begin
        step_r <= step_r + 6'd1;
      end else begin
        step_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Issue one matrix read a cycle: slot outer, row inner
  assign issue   = (state_r == vxf_pkg::ST_MAC) && (cnt_r != vxf_pkg::MAC_STEPS);
  assign iss_col = (cnt_r[3:2] == 2'd2 && proj_r) ? 2'd3 : cnt_r[3:2];
  assign rd_addr = {cnt_r[1:0], iss_col};

  // Matrix memory: write on request, registered read
  always_ff @(posedge clk) begin
    if (in_fire && in_req_type == vxf_pkg::REQ_WRITE) begin
      mat_mem[in_entry_index] <= in_entry_value;
    end
    rd_data_r <= mat_mem[rd_addr];
    rd_hit_r  <= ent_vld_r[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  // Pick the entry and the coordinate; the translation row multiplies by one
  always_comb begin
    ent_val = rd_hit_r ? rd_data_r : vxf_pkg::entry_reset(rd_idx_r);
    case (s1_row_r)
      2'd0:    op_val = pt_x_r;
      2'd1:    op_val = pt_y_r;
      2'd2:    op_val = pt_z_r;
      default: op_val = vxf_pkg::ONE_Q16;
    endcase
    prod_nxt = ent_val * op_val;
  end

  // Capture the request, run the product stage and the accumulators
  always_ff @(posedge clk) begin
    s1_row_r  <= cnt_r[1:0];
    s1_slot_r <= cnt_r[3:2];
    s2_slot_r <= s1_slot_r;
    prod_r    <= prod_nxt;
    if (in_fire) begin
      proj_r <= (in_req_type == vxf_pkg::REQ_PROJECT);
      pt_x_r <= in_point_x;
      pt_y_r <= in_point_y;
      pt_z_r <= in_point_z;
      for (int j = 0; j < vxf_pkg::LANES; j++) begin
        acc_r[j] <= vxf_pkg::ROUND_HALF;
      end
    end else if (s2_vld_r) begin
      acc_r[s2_slot_r] <= acc_r[s2_slot_r] + {{2{prod_r[vxf_pkg::PROD_W-1]}}, prod_r};
    end
  end

  // Column sums rounded to Q34.16 and divider operands
  always_comb begin
    for (int j = 0; j < vxf_pkg::LANES; j++) begin
      col_v[j] = acc_r[j][vxf_pkg::MAC_W-1:vxf_pkg::FRAC_W];
    end
    w_zero = (col_v[2] == '0);
    w_mag  = col_v[2][vxf_pkg::COL_W-1] ? -col_v[2] : col_v[2];
    for (int j = 0; j < 2; j++) begin
      num_neg[j] = col_v[j][vxf_pkg::COL_W-1];
      num_mag[j] = num_neg[j] ? -col_v[j] : col_v[j];
    end
    num_neg[2] = 1'b0;
    num_mag[2] = vxf_pkg::MAG_W'(vxf_pkg::ONE_Q16);
    for (int j = 0; j < vxf_pkg::LANES; j++) begin
      trial[j]    = {rem_r[j], lo_r[j][vxf_pkg::QUO_W-1]};
      diff[j]     = trial[j] - {1'b0, den_r};
      trial_ge[j] = (trial[j] >= {1'b0, den_r});
    end
  end

  // Divider lanes: load, then one restoring step a cycle
  always_ff @(posedge clk) begin
    if (state_r == vxf_pkg::ST_SETUP) begin
      den_r <= w_mag;
      for (int j = 0; j < vxf_pkg::LANES; j++) begin
        num_mag_r[j] <= num_mag[j];
        neg_r[j]     <= num_neg[j] ^ col_v[2][vxf_pkg::COL_W-1];
        rem_r[j]     <= num_mag[j] >> vxf_pkg::INIT_SH;
        lo_r[j]      <= {num_mag[j][vxf_pkg::INIT_SH-1:0], vxf_pkg::FRAC_W'(0)};
        quo_r[j]     <= '0;
      end
    end else if (state_r == vxf_pkg::ST_DIV) begin
      for (int j = 0; j < vxf_pkg::LANES; j++) begin
        rem_r[j] <= trial_ge[j] ? diff[j][vxf_pkg::MAG_W-1:0]
                                : trial[j][vxf_pkg::MAG_W-1:0];
        quo_r[j] <= {quo_r[j][vxf_pkg::QUO_W-2:0], trial_ge[j]};
        lo_r[j]  <= lo_r[j] << 1;
      end
    end
  end

  // Result values: clamp transforms, fault on zero w, round and clamp quotients
  always_comb begin
    logic                           ovf;
    logic                           rnd;
    logic                           over;
    logic [vxf_pkg::QR_W-1:0]       qr;
    logic [vxf_pkg::QR_W-1:0]       qv;
    res_load      = 1'b0;
    res_fault_nxt = 1'b0;
    res_sat_nxt   = 1'b0;
    ovf           = 1'b0;
    rnd           = 1'b0;
    over          = 1'b0;
    qr            = '0;
    qv            = '0;
    for (int j = 0; j < vxf_pkg::LANES; j++) begin
      res_nxt[j] = '0;
    end
    if (state_r == vxf_pkg::ST_SETUP && !proj_r) begin
      res_load = 1'b1;
      for (int j = 0; j < vxf_pkg::LANES; j++) begin
        if (col_v[j] > COL_HI) begin
          res_nxt[j]  = OUT_MAX;
          res_sat_nxt = 1'b1;
        end else if (col_v[j] < COL_LO) begin
          res_nxt[j]  = OUT_MIN;
          res_sat_nxt = 1'b1;
        end else begin
          res_nxt[j] = col_v[j][vxf_pkg::DATA_W-1:0];
        end
      end
    end else if (state_r == vxf_pkg::ST_SETUP && w_zero) begin
      // Zero w: saturate x and y toward the sign of each nonzero numerator, reciprocal to max
      res_load      = 1'b1;
      res_fault_nxt = 1'b1;
      res_sat_nxt   = 1'b1;
      for (int j = 0; j < 2; j++) begin
        if (col_v[j] == '0) begin
          res_nxt[j] = '0;
        end else if (col_v[j][vxf_pkg::COL_W-1]) begin
          res_nxt[j] = OUT_MIN;
        end else begin
          res_nxt[j] = OUT_MAX;
        end
      end
      res_nxt[2] = OUT_MAX;
    end else if (state_r == vxf_pkg::ST_ROUND) begin
      res_load = 1'b1;
      for (int j = 0; j < vxf_pkg::LANES; j++) begin
        ovf  = ({vxf_pkg::OVF_SH'(0), num_mag_r[j]} >= {den_r, vxf_pkg::OVF_SH'(0)});
        rnd  = ({rem_r[j], 1'b0} >= {1'b0, den_r});
        qr   = {1'b0, quo_r[j]} + vxf_pkg::QR_W'(rnd);
        over = ovf || (neg_r[j] ? (qr > QLIM_NEG) : (qr > QLIM_POS));
        qv   = neg_r[j] ? -qr : qr;
        if (over) begin
          res_nxt[j]  = neg_r[j] ? OUT_MIN : OUT_MAX;
          res_sat_nxt = 1'b1;
        end else begin
          res_nxt[j] = qv[vxf_pkg::DATA_W-1:0];
        end
      end
    end
  end

  // Hold the finished result, then hand it to the output register
  always_ff @(posedge clk) begin
    if (res_load) begin
      for (int j = 0; j < vxf_pkg::LANES; j++) begin
        res_r[j] <= res_nxt[j];
      end
      res_fault_r <= res_fault_nxt;
      res_sat_r   <= res_sat_nxt;
    end
    if (out_load) begin
      out_x_r     <= res_r[0];
      out_y_r     <= res_r[1];
      out_z_r     <= res_r[2];
      out_fault_r <= res_fault_r;
      out_sat_r   <= res_sat_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_z            = out_z_r;
  assign out_divide_fault = out_fault_r;
  assign out_saturated    = out_sat_r;

endmodule
